// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the soft-limit compander RTL.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with asynchronous active-low reset disable.
`define SLC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("slc assertion failed");
// Same-cycle implication.
`define SLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `SLC_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`else
`define SLC_ASSERT(lbl, clk, rstn, prop)
`define SLC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/slc_pkg.sv =====
// Package for the soft-limit compander: widths, curve constants, word types.
// No dependencies.
package slc_pkg;

  localparam int unsigned SAMPLE_W = 16;  // signed mix sample
  localparam int unsigned MAG_W    = 15;  // folded magnitude
  localparam int unsigned PCM_W    = 8;
  localparam int unsigned VC_W     = 5;   // voice count register
  localparam int unsigned SEG_W    = 7;   // 128 curve entries per voice
  localparam int unsigned Q_W      = 7;   // stored curve value, 0..127
  localparam int unsigned FRAC_W   = 8;   // fraction bits of the raw quotient
  localparam int unsigned I_W      = 11;  // curve index at most 16 voices
  localparam int unsigned KM_W     = 11;  // 127 * voices
  localparam int unsigned NUM_W    = 22;  // index * 127 * voices
  localparam int unsigned DEN_W    = 15;  // 127 * voices + index * (voices - 1)
  localparam int unsigned QUO_W    = 15;  // quotient with fraction, below 128 * 256

  localparam logic [KM_W-1:0]  CURVE_K    = 11'd127;
  localparam logic [QUO_W:0]   ROUND_HALF = 16'd128;
  localparam logic [Q_W-1:0]   Q_MAX      = 7'd127;
  localparam logic [PCM_W-1:0] PCM_MID    = 8'd128;
  localparam logic [PCM_W-1:0] PCM_BELOW  = 8'd127;
  localparam logic [PCM_W-1:0] PCM_MAX    = 8'd255;
  localparam logic [PCM_W-1:0] PCM_MIN    = 8'd0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_sample;
    logic                       frame_last;
  } slc_in_t;

  typedef struct packed {
    logic [PCM_W-1:0] pcm_byte;
    logic             frame_last_out;
  } slc_out_t;

endpackage

// ===== rtl/core/slc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/slc_curve_fill.sv =====
// Curve table builder: sweeps the indices for the current voice count through
// a pipelined restoring divider and writes rounded values. Uses slc_pkg.
`include "assert_macros.svh"
module slc_curve_fill #(
  parameter int unsigned MAX_VOICES = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        restart_i,
  input  logic [slc_pkg::VC_W-1:0]                    voices_i,
  output logic                                        busy_o,
  output logic                                        wr_en_o,
  output logic [$clog2((1 << slc_pkg::SEG_W) * MAX_VOICES)-1:0] wr_addr_o,
  output logic [slc_pkg::Q_W-1:0]                     wr_data_o
);
  import slc_pkg::*;

  localparam int unsigned DEPTH = (1 << SEG_W) * MAX_VOICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             issuing_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] limit;

  logic [I_W-1:0]   idx_ext;
  logic [KM_W-1:0]  km;
  logic [NUM_W-1:0] numer;
  logic [DEN_W-1:0] denom;

  logic [QUO_W:0]   st_v_q;
  logic [AW-1:0]    st_idx_q [QUO_W+1];
  logic [DEN_W-1:0] st_rem_q [QUO_W+1];
  logic [QUO_W-1:0] st_low_q [QUO_W+1];
  logic [DEN_W-1:0] st_den_q [QUO_W+1];
  logic [QUO_W-1:0] st_quo_q [QUO_W+1];

  logic [QUO_W:0]          rounded;
  logic [QUO_W-FRAC_W:0]   q_int;

  assign limit = CNT_W'(voices_i) << SEG_W;

  // Issue one index per cycle until the knee of the current curve.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b1;
      idx_q     <= '0;
    end else if (restart_i) begin
      issuing_q <= 1'b1;
      idx_q     <= '0;
    end else if (issuing_q) begin
      idx_q <= idx_q + CNT_W'(1);
      if (idx_q == limit - CNT_W'(1)) begin
        issuing_q <= 1'b0;
      end
    end
  end

  // Setup stage: numerator and denominator of the curve.
  assign idx_ext = I_W'(idx_q[AW-1:0]);
  assign km      = KM_W'(voices_i) * CURVE_K;
  assign numer   = NUM_W'(idx_ext) * NUM_W'(km);
  assign denom   = DEN_W'(km) + DEN_W'(idx_ext) * DEN_W'(voices_i - VC_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q[0] <= 1'b0;
    end else begin
      st_v_q[0] <= issuing_q & ~restart_i;
    end
  end

  // The dividend is numer << 8; its top 15 bits are below the divisor.
  always_ff @(posedge clk_i) begin
    st_idx_q[0] <= idx_q[AW-1:0];
    st_rem_q[0] <= numer[NUM_W-1:NUM_W-DEN_W];
    st_low_q[0] <= {numer[NUM_W-DEN_W-1:0], FRAC_W'(0)};
    st_den_q[0] <= denom;
    st_quo_q[0] <= '0;
  end

  // One quotient bit per stage.
  for (genvar s = 1; s <= QUO_W; s++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {st_rem_q[s-1], st_low_q[s-1][QUO_W-1]};
    assign diff  = trial - {1'b0, st_den_q[s-1]};
    assign ge    = trial >= {1'b0, st_den_q[s-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[s] <= 1'b0;
      end else begin
        st_v_q[s] <= st_v_q[s-1] & ~restart_i;
      end
    end

    always_ff @(posedge clk_i) begin
      st_idx_q[s] <= st_idx_q[s-1];
      st_rem_q[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      st_low_q[s] <= {st_low_q[s-1][QUO_W-2:0], 1'b0};
      st_den_q[s] <= st_den_q[s-1];
      st_quo_q[s] <= {st_quo_q[s-1][QUO_W-2:0], ge};
    end
  end

  // Round to the nearest whole step and hold at the top of the curve.
  assign rounded = {1'b0, st_quo_q[QUO_W]} + ROUND_HALF;
  assign q_int   = rounded[QUO_W:FRAC_W];

  assign wr_en_o   = st_v_q[QUO_W];
  assign wr_addr_o = st_idx_q[QUO_W];
  assign wr_data_o = (q_int > {1'b0, Q_MAX}) ? Q_MAX : q_int[Q_W-1:0];
  assign busy_o    = issuing_q | (|st_v_q);

  `SLC_ASSERT_IMP(a_wr_in_curve, clk_i, rst_ni, wr_en_o, CNT_W'(wr_addr_o) < limit)
  `SLC_ASSERT_IMP(a_rem_below_den, clk_i, rst_ni, wr_en_o,
                  st_rem_q[QUO_W] < st_den_q[QUO_W])
  `SLC_ASSERT(a_restart_rewinds, clk_i, rst_ni,
              restart_i |=> (issuing_q && idx_q == '0 && !st_v_q[0]))

endmodule

// ===== rtl/core/soft_limit_compander_pcm8.sv =====
// Top level of the soft-limit compander: 16-bit mix sample to 8-bit PCM.
// Uses slc_pkg, slc_curve_fill and slc_ram.
//
//   channel   direction  handshake                   word
//   -------   ---------  --------------------------  ------------------------
//   sample    in         start high, busy low        in_i  (slc_in_t)
//   result    out        res_valid_o, one cycle      res_o (slc_out_t)
//   config    in         cfg_valid_i and cfg_ready_o cfg_data_i (voice count)
//
// One sample word per cycle while busy is low; the fold and table read are
// registered, then the output register strobes the result. The curve lives in
// a RAM of 128 * MAX_VOICES entries; the sample path is one RAM read per word.
// After reset and after every config write the curve is rebuilt: busy stays
// high while the builder issues one index per cycle through a setup stage and
// a 15-stage divider, then drops. Config writes are always taken. The
// receiver cannot stall; nothing holds results back.
`include "assert_macros.svh"
module soft_limit_compander_pcm8 #(
  parameter int unsigned MAX_VOICES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  slc_pkg::slc_in_t          in_i,
  output logic                      res_valid_o,
  output slc_pkg::slc_out_t         res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [slc_pkg::VC_W-1:0]  cfg_data_i
);
  import slc_pkg::*;

  localparam int unsigned DEPTH = (1 << SEG_W) * MAX_VOICES;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic            cfg_fire;
  logic [VC_W-1:0] m_d;
  logic [VC_W-1:0] m_q;

  logic             accept;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] knee;
  logic             sat;

  logic            fill_wr_en;
  logic [AW-1:0]   fill_wr_addr;
  logic [Q_W-1:0]  fill_wr_data;
  logic [Q_W-1:0]  rd_data;

  logic            p_v_q;
  logic            p_neg_q;
  logic            p_sat_q;
  logic            p_last_q;

  logic [PCM_W-1:0] byte_d;
  logic             res_valid_q;
  slc_out_t         res_q;

  // Clamp the voice count into 1..MAX_VOICES on the way in.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    if (cfg_data_i == '0) begin
      m_d = VC_W'(1);
    end else if (cfg_data_i > VC_W'(MAX_VOICES)) begin
      m_d = VC_W'(MAX_VOICES);
    end else begin
      m_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= VC_W'(1);
    end else if (cfg_fire) begin
      m_q <= m_d;
    end
  end

  // Rebuild the curve table whenever the voice count is written.
  slc_curve_fill #(
    .MAX_VOICES(MAX_VOICES)
  ) u_fill (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_fire),
    .voices_i  (m_q),
    .busy_o    (busy),
    .wr_en_o   (fill_wr_en),
    .wr_addr_o (fill_wr_addr),
    .wr_data_o (fill_wr_data)
  );

  // Fold the sample: negative x maps to -x-1, which is the bitwise inverse.
  assign accept = start & ~busy;
  assign neg    = in_i.mix_sample[SAMPLE_W-1];
  assign mag    = neg ? ~in_i.mix_sample[SAMPLE_W-2:0] : in_i.mix_sample[SAMPLE_W-2:0];
  assign knee   = MAG_W'(m_q) << SEG_W;
  assign sat    = mag >= knee;

  // Curve RAM: written by the builder, read once per accepted word.
  slc_ram #(
    .WIDTH(Q_W),
    .DEPTH(DEPTH)
  ) u_curve (
    .clk_i     (clk_i),
    .wr_en_i   (fill_wr_en),
    .wr_addr_i (fill_wr_addr),
    .wr_data_i (fill_wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (mag[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Carry sign, saturation and frame flag alongside the RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_neg_q  <= neg;
      p_sat_q  <= sat;
      p_last_q <= in_i.frame_last;
    end
  end

  // Map the curve value around the silence code; rails at and beyond the knee.
  always_comb begin
    if (p_sat_q) begin
      byte_d = p_neg_q ? PCM_MIN : PCM_MAX;
    end else if (p_neg_q) begin
      byte_d = PCM_BELOW - PCM_W'(rd_data);
    end else begin
      byte_d = PCM_MID + PCM_W'(rd_data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_v_q) begin
      res_q.pcm_byte       <= byte_d;
      res_q.frame_last_out <= p_last_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SLC_ASSERT(a_res_latency, clk_i, rst_ni, res_valid_o == $past(accept, 2))
  `SLC_ASSERT(a_cfg_rebuilds, clk_i, rst_ni, cfg_fire |=> busy)
  `SLC_ASSERT_IMP(a_no_read_during_fill, clk_i, rst_ni, accept, !fill_wr_en)
  `SLC_ASSERT(a_sat_rail, clk_i, rst_ni,
              (p_v_q && p_sat_q) |=> (res_o.pcm_byte == PCM_MIN || res_o.pcm_byte == PCM_MAX))

endmodule

// ===== dv/tb_soft_limit_compander_pcm8.sv =====
// Self-checking testbench for soft_limit_compander_pcm8: a directed table, then random
// phases at several voice counts. Results are checked against typed rows or an in-bench predictor.
// Depends on slc_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps
module tb_soft_limit_compander_pcm8;
  import slc_pkg::*;

  localparam int unsigned MAX_VOICES  = 16;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 144;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  slc_in_t             in_i        = '0;
  logic                res_valid_o;
  slc_out_t            res_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [VC_W-1:0]     cfg_data_i  = '0;

  // Predictor copy of the voice count register (reset value 1).
  logic [VC_W-1:0]     voices_reg  = 5'd1;
  slc_out_t            pcm_expected[$];
  slc_out_t            oldest_word;
  int unsigned         mismatches  = 0;
  int unsigned         cycles      = 0;

  // Directed table row: either a voice count write or one sample word. Where
  // typed is set, the expected byte is taken from the row, else predicted.
  typedef struct packed {
    logic                       is_cfg;
    logic [VC_W-1:0]            voices;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       typed;
    logic [PCM_W-1:0]           pcm;
  } dir_row_t;

  //                     cfg   voices  sample         last  typed pcm
  dir_row_t dir_rows [0:27] = '{
    // voice count 1 after reset: the curve is the identity, clipped at 127
    '{1'b0, 5'd0,  16'sd0,       1'b0, 1'b1, 8'd128},
    '{1'b0, 5'd0,  -16'sd1,      1'b0, 1'b1, 8'd127},
    '{1'b0, 5'd0,  16'sd100,     1'b1, 1'b1, 8'd228},
    '{1'b0, 5'd0,  -16'sd101,    1'b0, 1'b1, 8'd27},
    '{1'b0, 5'd0,  16'sd127,     1'b0, 1'b1, 8'd255},
    '{1'b0, 5'd0,  16'sd128,     1'b0, 1'b1, 8'd255},
    '{1'b0, 5'd0,  -16'sd128,    1'b0, 1'b1, 8'd0},
    '{1'b0, 5'd0,  -16'sd129,    1'b0, 1'b1, 8'd0},
    '{1'b0, 5'd0,  16'sd32767,   1'b1, 1'b1, 8'd255},
    '{1'b0, 5'd0,  -16'sd32768,  1'b0, 1'b1, 8'd0},
    // full voice count: probe both sides of the saturation edge at 2048
    '{1'b1, 5'd16, 16'sd0,       1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  16'sd2047,    1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  16'sd2048,    1'b0, 1'b1, 8'd255},
    '{1'b0, 5'd0,  -16'sd2048,   1'b1, 1'b0, 8'd0},
    '{1'b0, 5'd0,  -16'sd2049,   1'b0, 1'b1, 8'd0},
    '{1'b0, 5'd0,  16'sd1,       1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  -16'sd32768,  1'b1, 1'b1, 8'd0},
    // zero voices behaves as one voice
    '{1'b1, 5'd0,  16'sd0,       1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  16'sd128,     1'b0, 1'b1, 8'd255},
    '{1'b0, 5'd0,  16'sd127,     1'b0, 1'b1, 8'd255},
    '{1'b0, 5'd0,  -16'sd1,      1'b1, 1'b1, 8'd127},
    // voice counts above the maximum behave as the maximum
    '{1'b1, 5'd31, 16'sd0,       1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  16'sd2048,    1'b0, 1'b1, 8'd255},
    '{1'b0, 5'd0,  16'sd2047,    1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  16'sd5000,    1'b0, 1'b1, 8'd255},
    '{1'b1, 5'd17, 16'sd0,       1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  16'sd2047,    1'b0, 1'b0, 8'd0},
    '{1'b0, 5'd0,  -16'sd2049,   1'b1, 1'b1, 8'd0}
  };

  soft_limit_compander_pcm8 #(
    .MAX_VOICES (MAX_VOICES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Clamp a raw register value to the voice count the curve actually uses.
  function automatic int unsigned used_voices(input logic [VC_W-1:0] raw);
    int unsigned m;
    m = raw;
    if (m < 1) m = 1;
    if (m > MAX_VOICES) m = MAX_VOICES;
    return m;
  endfunction

  // Soft-limit curve: fold the sample to a magnitude, saturate at and past 128*M,
  // else divide with 8 fraction bits and round to the nearest step.
  function automatic logic [PCM_W-1:0] soft_limit(input logic signed [SAMPLE_W-1:0] x,
                                                  input logic [VC_W-1:0] raw_voices);
    int unsigned       m;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   q;
    m   = used_voices(raw_voices);
    neg = x[SAMPLE_W-1];
    mag = neg ? ~x[MAG_W-1:0] : x[MAG_W-1:0];
    if (mag >= 128 * m) return neg ? PCM_MIN : PCM_MAX;
    num = 64'(mag) * 64'd127 * 64'(m);
    den = 64'd127 * 64'(m) + 64'(mag) * 64'(m - 1);
    q   = (((num << 8) / den) + 64'd128) >> 8;
    if (q > 127) q = 127;
    return neg ? PCM_W'(127 - q) : PCM_W'(128 + q);
  endfunction

  // Hold until every expected result word has come back.
  task automatic wait_drained();
    while (pcm_expected.size() != 0) @(posedge clk_i);
  endtask

  // Write the voice count with the sample side idle and drained; the block
  // rebuilds its curve afterwards and shows that through busy.
  task automatic write_voices(input logic [VC_W-1:0] value);
    start <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    voices_reg  = value;
  endtask

  // Offer one sample word after an optional gap; keep start high on return so
  // that a back-to-back word needs no second assignment in the same step.
  task automatic send_sample(input slc_in_t w, input slc_out_t exp_w,
                             input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= w;
    do @(posedge clk_i); while (busy);
    pcm_expected.push_back(exp_w);
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    slc_in_t          w;
    slc_out_t         exp_w;
    logic [VC_W-1:0]  phase_voices;
    int unsigned      em;
    int unsigned      mode;
    int unsigned      mag;
    bit               calm;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: configuration rows, typed rows and predicted rows.
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        write_voices(dir_rows[k].voices);
      end else begin
        w.mix_sample         = dir_rows[k].sample;
        w.frame_last         = dir_rows[k].last;
        exp_w.pcm_byte       = dir_rows[k].typed ? dir_rows[k].pcm
                                                 : soft_limit(w.mix_sample, voices_reg);
        exp_w.frame_last_out = w.frame_last;
        send_sample(w, exp_w, pick_gap());
      end
    end

    // Random phases; the voice count changes between them, extremes first.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_voices = 5'd1;
        1:       phase_voices = 5'd16;
        2:       phase_voices = 5'd0;
        3:       phase_voices = 5'd31;
        4:       phase_voices = VC_W'($urandom_range(2, 15));
        default: phase_voices = VC_W'($urandom_range(0, 31));
      endcase
      write_voices(phase_voices);
      em   = used_voices(phase_voices);
      calm = (p % 3 == 1);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        mode = $urandom_range(0, 9);
        if (mode <= 3) begin
          // inside the curve, where the division matters
          mag = $urandom_range(0, 128 * em - 1);
          w.mix_sample = $urandom_range(0, 1) ? SAMPLE_W'(-int'(mag) - 1) : SAMPLE_W'(mag);
        end else if (mode <= 5) begin
          // around the saturation edge
          mag = 128 * em + $urandom_range(0, 4) - 2;
          w.mix_sample = $urandom_range(0, 1) ? SAMPLE_W'(-int'(mag) - 1) : SAMPLE_W'(mag);
        end else if (mode <= 8) begin
          w.mix_sample = SAMPLE_W'($urandom());
        end else begin
          case ($urandom_range(0, 3))
            0:       w.mix_sample = 16'sd32767;
            1:       w.mix_sample = -16'sd32768;
            2:       w.mix_sample = 16'sd0;
            default: w.mix_sample = -16'sd1;
          endcase
        end
        w.frame_last         = ($urandom_range(0, 7) == 0);
        exp_w.pcm_byte       = soft_limit(w.mix_sample, voices_reg);
        exp_w.frame_last_out = w.frame_last;
        send_sample(w, exp_w, calm ? 0 : pick_gap());
      end
    end

    // Drop start, drain, then let the pipeline settle before the verdict.
    start <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result checker: every strobe must match the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pcm_expected.size() == 0) begin
        $error("result word with nothing expected: pcm_byte %0d", res_o.pcm_byte);
        mismatches++;
      end else begin
        oldest_word = pcm_expected.pop_front();
        if (res_o.pcm_byte !== oldest_word.pcm_byte) begin
          $error("pcm_byte: expected %0d, actual %0d", oldest_word.pcm_byte, res_o.pcm_byte);
          mismatches++;
        end
        if (res_o.frame_last_out !== oldest_word.frame_last_out) begin
          $error("frame_last_out: expected %0d, actual %0d",
                 oldest_word.frame_last_out, res_o.frame_last_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if it stalls well beyond the slowest correct case.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
